@@ rtl/bls_pkg.sv @@
`default_nettype none

package bls_pkg;

    // Operating modes of the supervisor.
    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_OPENING = 2'd1,
        MODE_FAULT   = 2'd2
    } t_mode;

    // Input event codes.
    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_REPORT    = 2'd1,
        OP_HEARTBEAT = 2'd2,
        OP_COMMAND   = 2'd3
    } t_op;

    // Result event codes.
    typedef enum logic [2:0] {
        EV_CHARGE_ON  = 3'd0,
        EV_CHARGE_OFF = 3'd1,
        EV_PERCENT    = 3'd2,
        EV_FAULT      = 3'd3,
        EV_OK         = 3'd4,
        EV_SEND       = 3'd5
    } t_kind;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_CHECK_PERIOD = 2'd0,
        REG_OPEN_TIMEOUT = 2'd1,
        REG_OPEN_TRIES   = 2'd2
    } t_reg;

    // The command frame is AA 02 02 v; the checksum covers length, opcode and value.
    localparam logic [7:0] FRAME_LEN = 8'h02;
    localparam logic [7:0] FRAME_CMD = 8'h02;

    localparam logic [15:0] CHECK_PERIOD_RESET = 16'd9000;
    localparam logic [15:0] OPEN_TIMEOUT_RESET = 16'd300;
    localparam logic [3:0]  OPEN_TRIES_RESET   = 4'd2;
    localparam logic [3:0]  SENDS_MAX          = 4'd15;

    // At most three results come from one event (ok, charge change, percent).
    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  value;
        logic [7:0]  checksum;
    } t_result;

    // All results caused by one input event.
    typedef struct packed {
        logic [1:0]                     count;
        t_result [MAX_RESULTS-1:0]      res;
    } t_bundle;

    // A timer load of zero counts as one tick.
    function automatic logic [15:0] load_of(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/bls_front.sv @@
`default_nettype none

module bls_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire logic            i_q_full,
    input  wire logic [1:0]      i_operation,
    input  wire logic            i_report_charging,
    input  wire logic            i_report_outputing,
    input  wire logic [6:0]      i_report_percent,
    input  wire logic [7:0]      i_command_value,
    input  wire logic            i_cfg_wr_en,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [15:0]     i_cfg_data,
    output logic                 o_q_push,
    output bls_pkg::t_bundle     o_q_data
);
    import bls_pkg::*;

    // Configuration registers.
    logic [15:0] r_check_period;
    logic [15:0] r_open_timeout;
    logic [3:0]  r_open_tries;

    // Supervisor state.
    t_mode       r_mode, n_mode;
    logic        r_hb_seen, n_hb_seen;
    logic [15:0] r_check_timer, n_check_timer;
    logic [15:0] r_open_timer, n_open_timer;
    logic [3:0]  r_sends_done, n_sends_done;
    logic [7:0]  r_cmd_out, n_cmd_out;
    logic        r_charging, n_charging;
    logic        r_outputing, n_outputing;
    logic [6:0]  r_percent, n_percent;

    logic        accept;

    assign accept = i_push && !i_q_full;

    // Configuration writes; an index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_period <= CHECK_PERIOD_RESET;
            r_open_timeout <= OPEN_TIMEOUT_RESET;
            r_open_tries   <= OPEN_TRIES_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg'(i_cfg_index))
                REG_CHECK_PERIOD: r_check_period <= i_cfg_data;
                REG_OPEN_TIMEOUT: r_open_timeout <= i_cfg_data;
                REG_OPEN_TRIES:   r_open_tries   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_IDLE;
            r_hb_seen     <= 1'b0;
            r_check_timer <= CHECK_PERIOD_RESET;
            r_open_timer  <= 16'd0;
            r_sends_done  <= 4'd0;
            r_cmd_out     <= 8'd0;
            r_charging    <= 1'b0;
            r_outputing   <= 1'b0;
            r_percent     <= 7'd0;
        end else begin
            r_mode        <= n_mode;
            r_hb_seen     <= n_hb_seen;
            r_check_timer <= n_check_timer;
            r_open_timer  <= n_open_timer;
            r_sends_done  <= n_sends_done;
            r_cmd_out     <= n_cmd_out;
            r_charging    <= n_charging;
            r_outputing   <= n_outputing;
            r_percent     <= n_percent;
        end
    end

    // Classify the event, update the state and collect its results.
    always_comb begin
        t_bundle    b;
        logic [1:0] k;
        logic       check_fire;
        logic       open_fire;
        logic [3:0] sends;
        t_mode      mode_now;
        logic       matched;

        b             = '0;
        k             = 2'd0;
        check_fire    = 1'b0;
        open_fire     = 1'b0;
        sends         = r_sends_done;
        mode_now      = r_mode;
        matched       = 1'b0;
        n_mode        = r_mode;
        n_hb_seen     = r_hb_seen;
        n_check_timer = r_check_timer;
        n_open_timer  = r_open_timer;
        n_sends_done  = r_sends_done;
        n_cmd_out     = r_cmd_out;
        n_charging    = r_charging;
        n_outputing   = r_outputing;
        n_percent     = r_percent;

        if (accept) begin
            unique case (t_op'(i_operation))
                OP_TICK: begin
                    if (r_mode != MODE_FAULT) begin
                        if (r_check_timer > 16'd1) begin
                            n_check_timer = r_check_timer - 16'd1;
                        end else begin
                            check_fire    = 1'b1;
                            n_check_timer = load_of(r_check_period);
                        end
                        if (r_mode == MODE_OPENING) begin
                            if (r_open_timer > 16'd1) begin
                                n_open_timer = r_open_timer - 16'd1;
                            end else begin
                                open_fire    = 1'b1;
                                n_open_timer = 16'd0;
                            end
                        end
                        // A missed heartbeat wins over the open timeout.
                        if (check_fire && !r_hb_seen) begin
                            n_mode        = MODE_FAULT;
                            n_open_timer  = 16'd0;
                            n_check_timer = 16'd0;
                            b.res[k]      = '{kind: EV_FAULT, value: 8'd0, checksum: 8'd0};
                            k             = k + 2'd1;
                        end else begin
                            if (check_fire) begin
                                n_hb_seen = 1'b0;
                            end
                            if (open_fire) begin
                                sends = (r_sends_done < SENDS_MAX) ?
                                        r_sends_done + 4'd1 : r_sends_done;
                                n_sends_done = sends;
                                if (sends < r_open_tries) begin
                                    n_mode       = MODE_OPENING;
                                    n_open_timer = load_of(r_open_timeout);
                                    b.res[k]     = '{kind: EV_SEND, value: r_cmd_out,
                                                     checksum: FRAME_LEN + FRAME_CMD
                                                               + r_cmd_out};
                                    k            = k + 2'd1;
                                end else begin
                                    n_mode       = MODE_IDLE;
                                    n_open_timer = 16'd0;
                                end
                            end
                        end
                    end
                end
                OP_REPORT: begin
                    if (r_mode == MODE_FAULT) begin
                        b.res[k]      = '{kind: EV_OK, value: 8'd0, checksum: 8'd0};
                        k             = k + 2'd1;
                        mode_now      = MODE_IDLE;
                        n_hb_seen     = 1'b0;
                        n_check_timer = load_of(r_check_period);
                    end
                    n_mode = mode_now;
                    if (i_report_charging != r_charging) begin
                        n_charging = i_report_charging;
                        b.res[k]   = '{kind: i_report_charging ? EV_CHARGE_ON : EV_CHARGE_OFF,
                                       value: 8'd0, checksum: 8'd0};
                        k          = k + 2'd1;
                    end
                    // The flag is compared against the whole commanded byte.
                    matched     = (i_report_outputing != r_outputing) &&
                                  ({7'd0, i_report_outputing} == r_cmd_out);
                    n_outputing = i_report_outputing;
                    if (i_report_percent != r_percent) begin
                        n_percent = i_report_percent;
                        b.res[k]  = '{kind: EV_PERCENT, value: {1'b0, i_report_percent},
                                      checksum: 8'd0};
                        k         = k + 2'd1;
                    end
                    if (matched && mode_now == MODE_OPENING) begin
                        n_mode       = MODE_IDLE;
                        n_open_timer = 16'd0;
                    end
                end
                OP_HEARTBEAT: begin
                    if (r_mode == MODE_FAULT) begin
                        b.res[k]      = '{kind: EV_OK, value: 8'd0, checksum: 8'd0};
                        k             = k + 2'd1;
                        n_mode        = MODE_IDLE;
                        n_check_timer = load_of(r_check_period);
                    end
                    n_hb_seen = 1'b1;
                end
                OP_COMMAND: begin
                    if (r_mode != MODE_FAULT) begin
                        n_cmd_out    = i_command_value;
                        n_sends_done = 4'd0;
                        n_mode       = MODE_OPENING;
                        n_open_timer = load_of(r_open_timeout);
                        b.res[k]     = '{kind: EV_SEND, value: i_command_value,
                                         checksum: FRAME_LEN + FRAME_CMD + i_command_value};
                        k            = k + 2'd1;
                    end
                end
            endcase
        end

        b.count  = k;
        o_q_data = b;
        o_q_push = accept && (k != 2'd0);
    end

endmodule

`default_nettype wire

@@ rtl/bls_queue.sv @@
`default_nettype none

module bls_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  bls_pkg::t_bundle     i_data,
    output logic                 o_full,
    input  wire logic            i_pop,
    output bls_pkg::t_bundle     o_data,
    output logic                 o_empty
);
    import bls_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_bundle          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage for waiting bundles.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bls_back.sv @@
`default_nettype none

module bls_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_empty,
    input  bls_pkg::t_bundle     i_q_data,
    output logic                 o_q_pop,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output logic [2:0]           o_event_kind,
    output logic [7:0]           o_event_value,
    output logic [7:0]           o_frame_checksum,
    output logic                 o_last
);
    import bls_pkg::*;

    t_bundle    r_bundle, n_bundle;
    logic [1:0] r_idx, n_idx;
    logic       r_busy, n_busy;
    logic       last_item;
    logic       advance;
    logic       can_load;
    t_result    cur;

    assign last_item = (r_idx == r_bundle.count - 2'd1);
    assign advance   = r_busy && i_pop;
    assign can_load  = !r_busy || (advance && last_item);
    assign o_q_pop   = can_load && !i_q_empty;

    // Step through the results of the current bundle, then load the next.
    always_comb begin
        n_bundle = r_bundle;
        n_idx    = r_idx;
        n_busy   = r_busy;
        if (o_q_pop) begin
            n_bundle = i_q_data;
            n_idx    = 2'd0;
            n_busy   = 1'b1;
        end else if (advance) begin
            if (last_item) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bundle <= n_bundle;
    end

    // Present the current result.
    assign cur              = r_bundle.res[r_idx];
    assign o_empty          = !r_busy;
    assign o_event_kind     = cur.kind;
    assign o_event_value    = cur.value;
    assign o_frame_checksum = cur.checksum;
    assign o_last           = last_item;

endmodule

`default_nettype wire

@@ rtl/battery_link_supervisor.sv @@
// Battery link supervisor.
// Input channel: an event (tick, status report, heartbeat or output command)
// transfers at a rising edge with push high and full low. Result channel: the
// oldest result sits on the o_ result ports while empty is low and transfers
// at a rising edge with pop high. An event yields zero to three results; the
// final one of an event carries o_last.
// Configuration: i_cfg_wr_en writes i_cfg_data into register i_cfg_index
// (0 check period, 1 open timeout, 2 open tries) at the edge; write only
// while no results are pending.
// Timing: an event's results pass through the bundle queue and then the result
// stage register before the first is visible. The event decoder takes one event
// per cycle while full is low; the result stage hands out one result per cycle
// while pop is high. A two-entry queue of result bundles between the decoder and
// the result stage sets how far the input runs ahead of a stalled receiver;
// once it is full, full stays high until pop drains a bundle.
// Reset: all modes, timers and flags return to their reset values, the
// configuration registers to 9000, 300 and 2, and both sides come up empty.
`default_nettype none

module battery_link_supervisor (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_operation,
    input  wire logic        i_report_charging,
    input  wire logic        i_report_outputing,
    input  wire logic [6:0]  i_report_percent,
    input  wire logic [7:0]  i_command_value,
    input  wire logic        pop,
    output logic             empty,
    output logic [2:0]       o_event_kind,
    output logic [7:0]       o_event_value,
    output logic [7:0]       o_frame_checksum,
    output logic             o_last,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import bls_pkg::*;

    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;
    t_bundle q_wr_data;
    t_bundle q_rd_data;

    assign full = q_full;

    // Event decoder and state.
    bls_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push),
        .i_q_full           (q_full),
        .i_operation        (i_operation),
        .i_report_charging  (i_report_charging),
        .i_report_outputing (i_report_outputing),
        .i_report_percent   (i_report_percent),
        .i_command_value    (i_command_value),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_q_push           (q_push),
        .o_q_data           (q_wr_data)
    );

    // Bundle queue between decoder and result stage.
    bls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rd_data),
        .o_empty (q_empty)
    );

    // Result serializer.
    bls_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_q_data         (q_rd_data),
        .o_q_pop          (q_pop),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_event_kind     (o_event_kind),
        .o_event_value    (o_event_value),
        .o_frame_checksum (o_frame_checksum),
        .o_last           (o_last)
    );

endmodule

`default_nettype wire

@@ rtl/bls_checker.sv @@
`default_nettype none

module bls_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        pop,
    input  wire logic        empty,
    input  wire logic [2:0]  o_event_kind,
    input  wire logic [7:0]  o_event_value,
    input  wire logic [7:0]  o_frame_checksum,
    input  wire logic        o_last
);
    import bls_pkg::*;

    // Nothing is waiting right after reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result channel not empty after reset");

    // A send command carries the frame checksum of its value.
    a_send_checksum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_event_kind == EV_SEND) |->
            (o_frame_checksum == 8'(FRAME_LEN + FRAME_CMD + o_event_value)))
        else $error("send command checksum mismatch");

    // Charge, fault and ok events carry neither a value nor a checksum.
    a_plain_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_event_kind == EV_CHARGE_ON || o_event_kind == EV_CHARGE_OFF ||
                    o_event_kind == EV_FAULT || o_event_kind == EV_OK)) |->
            (o_event_value == 8'd0 && o_frame_checksum == 8'd0))
        else $error("non-zero fields on a plain event");

    // A fault is always the only result of its event.
    a_fault_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_event_kind == EV_FAULT) |-> o_last)
        else $error("fault event not marked last");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(o_event_kind) && $stable(o_event_value) &&
             $stable(o_frame_checksum) && $stable(o_last)))
        else $error("stalled result changed");

endmodule

bind battery_link_supervisor bls_checker u_bls_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .pop              (pop),
    .empty            (empty),
    .o_event_kind     (o_event_kind),
    .o_event_value    (o_event_value),
    .o_frame_checksum (o_frame_checksum),
    .o_last           (o_last)
);

`default_nettype wire

@@ dv/testbench.sv @@
`default_nettype none

module testbench;
    import bls_pkg::*;

    // One event offered on the input side.
    typedef struct {
        t_op         op;
        bit          charging;
        bit          outputing;
        logic [6:0]  percent;
        logic [7:0]  value;
    } t_link_event;

    // One result as it should leave the block.
    typedef struct {
        t_kind       kind;
        logic [7:0]  value;
        logic [7:0]  checksum;
        bit          last;
    } t_pack_result;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 90;
    localparam int HOLD_AFTER  = 60;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        push         = 1'b0;
    logic        full;
    logic [1:0]  ev_op        = OP_TICK;
    logic        ev_charging  = 1'b0;
    logic        ev_outputing = 1'b0;
    logic [6:0]  ev_percent   = 7'd0;
    logic [7:0]  ev_value     = 8'd0;
    logic        pop          = 1'b0;
    logic        empty;
    logic [2:0]  o_event_kind;
    logic [7:0]  o_event_value;
    logic [7:0]  o_frame_checksum;
    logic        o_last;
    logic        cfg_wr_en    = 1'b0;
    logic [1:0]  cfg_index    = REG_CHECK_PERIOD;
    logic [15:0] cfg_data     = 16'd0;

    battery_link_supervisor dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_operation        (ev_op),
        .i_report_charging  (ev_charging),
        .i_report_outputing (ev_outputing),
        .i_report_percent   (ev_percent),
        .i_command_value    (ev_value),
        .pop                (pop),
        .empty              (empty),
        .o_event_kind       (o_event_kind),
        .o_event_value      (o_event_value),
        .o_frame_checksum   (o_frame_checksum),
        .o_last             (o_last),
        .i_cfg_wr_en        (cfg_wr_en),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    // Shadow copy of the configuration registers.
    logic [15:0] period_cfg  = CHECK_PERIOD_RESET;
    logic [15:0] timeout_cfg = OPEN_TIMEOUT_RESET;
    logic [3:0]  tries_cfg   = OPEN_TRIES_RESET;

    // Shadow copy of the supervisor state.
    t_mode       sv_mode   = MODE_IDLE;
    bit          hb_seen   = 1'b0;
    logic [15:0] check_cnt = CHECK_PERIOD_RESET;
    logic [15:0] open_cnt  = 16'd0;
    logic [3:0]  sends_cnt = 4'd0;
    logic [7:0]  cmd_byte  = 8'd0;
    bit          chg_seen  = 1'b0;
    bit          out_seen  = 1'b0;
    logic [6:0]  pct_seen  = 7'd0;

    t_link_event  pending_events[$];
    t_pack_result results_due[$];
    t_pack_result event_results[$];

    int n_queued     = 0;
    int n_sent       = 0;
    int n_results    = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;
    int steady_from  = 0;
    int steady_to    = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    logic [6:0] pct_gen = 7'd0;

    wire steady = (n_sent >= steady_from) && (n_sent < steady_to);

    // A timer is never loaded with zero ticks.
    function automatic logic [15:0] ticks_or_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function automatic void post_result(input t_kind kind, input logic [7:0] value,
                                        input logic [7:0] sum);
        event_results.push_back('{kind, value, sum, 1'b0});
    endfunction

    // Send the command frame and arm the confirmation timeout.
    function automatic void send_frame();
        sv_mode  = MODE_OPENING;
        open_cnt = ticks_or_one(timeout_cfg);
        post_result(EV_SEND, cmd_byte, FRAME_LEN + FRAME_CMD + cmd_byte);
    endfunction

    function automatic void raise_fault();
        sv_mode   = MODE_FAULT;
        open_cnt  = 16'd0;
        check_cnt = 16'd0;
        post_result(EV_FAULT, 8'd0, 8'd0);
    endfunction

    function automatic void clear_fault();
        post_result(EV_OK, 8'd0, 8'd0);
        sv_mode   = MODE_IDLE;
        hb_seen   = 1'b0;
        check_cnt = ticks_or_one(period_cfg);
    endfunction

    // Status report: flag and level changes, and the early end of opening.
    function automatic void apply_report(input t_link_event ev);
        bit matched;
        matched = 1'b0;
        if (ev.charging != chg_seen) begin
            chg_seen = ev.charging;
            post_result(ev.charging ? EV_CHARGE_ON : EV_CHARGE_OFF, 8'd0, 8'd0);
        end
        if (ev.outputing != out_seen) begin
            out_seen = ev.outputing;
            matched = ({7'd0, out_seen} == cmd_byte);
        end
        if (ev.percent != pct_seen) begin
            pct_seen = ev.percent;
            post_result(EV_PERCENT, {1'b0, ev.percent}, 8'd0);
        end
        if (matched && sv_mode == MODE_OPENING) begin
            sv_mode  = MODE_IDLE;
            open_cnt = 16'd0;
        end
    endfunction

    // Tick: the check timer is served before the open timeout.
    function automatic void apply_tick();
        bit check_fire;
        bit open_fire;
        check_fire = 1'b0;
        open_fire  = 1'b0;
        if (sv_mode == MODE_FAULT) return;
        if (check_cnt > 16'd1) begin
            check_cnt--;
        end else begin
            check_fire = 1'b1;
            check_cnt  = ticks_or_one(period_cfg);
        end
        if (sv_mode == MODE_OPENING) begin
            if (open_cnt > 16'd1) begin
                open_cnt--;
            end else begin
                open_fire = 1'b1;
                open_cnt  = 16'd0;
            end
        end
        if (check_fire) begin
            if (hb_seen) begin
                hb_seen = 1'b0;
            end else begin
                raise_fault();
                return;
            end
        end
        if (open_fire) begin
            if (sends_cnt < SENDS_MAX) sends_cnt++;
            if (sends_cnt < tries_cfg) begin
                send_frame();
            end else begin
                sv_mode  = MODE_IDLE;
                open_cnt = 16'd0;
            end
        end
    endfunction

    // Work out the results of one input transfer and queue them.
    function automatic void supervise_event(input t_link_event ev);
        event_results.delete();
        case (ev.op)
            OP_TICK: begin
                apply_tick();
            end
            OP_REPORT: begin
                if (sv_mode == MODE_FAULT) clear_fault();
                apply_report(ev);
            end
            OP_HEARTBEAT: begin
                if (sv_mode == MODE_FAULT) clear_fault();
                hb_seen = 1'b1;
            end
            default: begin
                if (sv_mode != MODE_FAULT) begin
                    cmd_byte  = ev.value;
                    sends_cnt = 4'd0;
                    send_frame();
                end
            end
        endcase
        if (event_results.size() > 0) event_results[event_results.size() - 1].last = 1'b1;
        foreach (event_results[i]) results_due.push_back(event_results[i]);
    endfunction

    function automatic t_link_event make_event(input t_op op, input bit chg, input bit outp,
                                               input logic [6:0] pct, input logic [7:0] val);
        return '{op, chg, outp, pct, val};
    endfunction

    function automatic void queue_event(input t_link_event ev);
        pending_events.push_back(ev);
        n_queued++;
    endfunction

    // Mostly ticks and reports, with enough heartbeats to keep the link alive.
    function automatic t_link_event random_event();
        t_link_event ev;
        int r;
        r = $urandom_range(0, 99);
        ev.op = (r < 45) ? OP_TICK : (r < 70) ? OP_REPORT : (r < 85) ? OP_HEARTBEAT : OP_COMMAND;
        ev.charging  = 1'($urandom_range(0, 1));
        ev.outputing = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r >= 45) pct_gen = 7'($urandom_range(0, 127));
        else if (r >= 35) pct_gen = 7'd127;
        else if (r >= 25) pct_gen = 7'd0;
        ev.percent = pct_gen;
        ev.value = $urandom_range(0, 1) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(0, 255));
        return ev;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("mismatch on result %0d: %s", n_results, what);
    endtask

    task automatic write_reg(input t_reg idx, input logic [15:0] val);
        @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_CHECK_PERIOD: period_cfg  = val;
            REG_OPEN_TIMEOUT: timeout_cfg = val;
            default:          tries_cfg   = val[3:0];
        endcase
    endtask

    // Registers change only once the block has drained and settled.
    task automatic set_config(input logic [15:0] period, input logic [15:0] timeout,
                              input logic [3:0] tries);
        while (pending_events.size() != 0 || results_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        write_reg(REG_CHECK_PERIOD, period);
        write_reg(REG_OPEN_TIMEOUT, timeout);
        write_reg(REG_OPEN_TRIES, {12'd0, tries});
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Predict the results of each input transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            supervise_event(pending_events[0]);
            void'(pending_events.pop_front());
            n_sent++;
        end
    end

    // Offer the oldest pending event, idling at random outside the steady stretch.
    always @(negedge i_clk) begin
        if (i_rst_n && pending_events.size() > 0 && (steady || $urandom_range(0, 99) >= 37)) begin
            push         <= 1'b1;
            ev_op        <= pending_events[0].op;
            ev_charging  <= pending_events[0].charging;
            ev_outputing <= pending_events[0].outputing;
            ev_percent   <= pending_events[0].percent;
            ev_value     <= pending_events[0].value;
        end else begin
            push <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off so the input backs up.
    always @(negedge i_clk) begin
        if (!hold_done && n_results >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= steady || ($urandom_range(0, 99) >= 37);
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_pack_result want;
        if (i_rst_n && pop && !empty) begin
            n_results++;
            if (results_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result, kind %0d", o_event_kind));
            end else begin
                want = results_due.pop_front();
                if (o_event_kind != want.kind)
                    flag_mismatch($sformatf("kind %0d, expected %0d", o_event_kind, want.kind));
                if (o_event_value != want.value)
                    flag_mismatch($sformatf("value %0d, expected %0d", o_event_value, want.value));
                if (o_frame_checksum != want.checksum)
                    flag_mismatch($sformatf("checksum %0d, expected %0d",
                                            o_frame_checksum, want.checksum));
                if (o_last != want.last)
                    flag_mismatch($sformatf("last %0b, expected %0b", o_last, want.last));
            end
        end
    end

    // End the run if no transfer happens on either side for too long.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("** battery_link_supervisor: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: flag and level extremes, commands and the output match.
        queue_event(make_event(OP_REPORT, 1'b1, 1'b1, 7'd127, 8'd0));
        queue_event(make_event(OP_REPORT, 1'b0, 1'b0, 7'd0, 8'd0));
        queue_event(make_event(OP_COMMAND, 1'b0, 1'b0, 7'd0, 8'hFF));
        queue_event(make_event(OP_COMMAND, 1'b0, 1'b0, 7'd0, 8'h01));
        queue_event(make_event(OP_REPORT, 1'b0, 1'b1, 7'd0, 8'd0));
        queue_event(make_event(OP_COMMAND, 1'b1, 1'b1, 7'd127, 8'h00));
        // A few ticks while opening; both timers are still far from expiring.
        repeat (10) queue_event(make_event(OP_TICK, 1'b0, 1'b0, 7'd0, 8'd0));

        // Zero registers load as one tick and zero tries act as one send.
        set_config(16'd0, 16'd0, 4'd0);
        queue_event(make_event(OP_TICK, 1'b0, 1'b0, 7'd0, 8'd0));
        queue_event(make_event(OP_COMMAND, 1'b0, 1'b0, 7'd0, 8'h55));
        queue_event(make_event(OP_HEARTBEAT, 1'b0, 1'b0, 7'd0, 8'd0));
        queue_event(make_event(OP_TICK, 1'b0, 1'b0, 7'd0, 8'd0));
        queue_event(make_event(OP_COMMAND, 1'b0, 1'b0, 7'd0, 8'h80));
        // A one-tick timeout gives up on the very next tick.
        queue_event(make_event(OP_TICK, 1'b0, 1'b0, 7'd0, 8'd0));
        // A report with both a charge change and a level change.
        queue_event(make_event(OP_REPORT, 1'b1, 1'b0, 7'd50, 8'd0));
        queue_event(make_event(OP_HEARTBEAT, 1'b0, 1'b0, 7'd0, 8'd0));
        queue_event(make_event(OP_COMMAND, 1'b0, 1'b0, 7'd0, 8'h7F));
        queue_event(make_event(OP_TICK, 1'b0, 1'b0, 7'd0, 8'd0));
        queue_event(make_event(OP_TICK, 1'b0, 1'b0, 7'd0, 8'd0));

        // Random phases over several register settings.
        set_config(16'd8, 16'd3, 4'd3);
        repeat (60) queue_event(random_event());

        set_config(16'd20, 16'd5, 4'd15);
        steady_from = n_queued;
        steady_to   = n_queued + 60;
        repeat (60) queue_event(random_event());

        set_config(16'd2, 16'd1, 4'd1);
        repeat (60) queue_event(random_event());

        set_config(16'($urandom_range(4, 30)), 16'($urandom_range(1, 8)),
                   4'($urandom_range(1, 15)));
        repeat (60) queue_event(random_event());

        set_config(16'hFFFF, 16'hFFFF, 4'd15);
        repeat (20) queue_event(random_event());

        while (pending_events.size() != 0 || results_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("** battery_link_supervisor: PASSED **");
        end else begin
            $display("** battery_link_supervisor: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
